FILE: rtl/gzhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzhc_pkg
// Shared constants, types and CRC helpers for the gzip member header checker.
// ----------------------------------------------------------------------------
package gzhc_pkg;

  // parse phases
  localparam logic [2:0] PH_FIXED   = 3'd0;
  localparam logic [2:0] PH_XLEN    = 3'd1;
  localparam logic [2:0] PH_XDATA   = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_COMMENT = 3'd4;
  localparam logic [2:0] PH_HCRC_LO = 3'd5;
  localparam logic [2:0] PH_HCRC_HI = 3'd6;
  localparam logic [2:0] PH_BODY    = 3'd7;

  // FLG bit positions
  localparam int FL_HCRC    = 1;
  localparam int FL_EXTRA   = 2;
  localparam int FL_NAME    = 3;
  localparam int FL_COMMENT = 4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_METHOD    = 3'd3;
  localparam logic [2:0] ST_RSV_FLAGS = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_HDR_CRC   = 3'd6;
  localparam logic [2:0] ST_TOO_LARGE = 3'd7;

  localparam logic [7:0]  ID1        = 8'h1F;
  localparam logic [7:0]  ID2        = 8'h8B;
  localparam logic [7:0]  CM_DEFLATE = 8'h08;
  localparam logic [31:0] MIN_MEMBER = 32'd18;
  localparam logic [31:0] TRAILER    = 32'd8;
  localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  // state of the parser as seen after the final word of a member
  typedef struct packed {
    logic [31:0] total;
    logic [2:0]  err;
    logic        body;
    logic [31:0] pstart;
    logic [63:0] tail;
  } final_t;

  // reflected CRC-32, four bits per lookup
  function automatic logic [31:0] crc_nib(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'h0: v = 32'h00000000;  4'h1: v = 32'h1DB71064;
      4'h2: v = 32'h3B6E20C8;  4'h3: v = 32'h26D930AC;
      4'h4: v = 32'h76DC4190;  4'h5: v = 32'h6B6B51F4;
      4'h6: v = 32'h4DB26158;  4'h7: v = 32'h5005713C;
      4'h8: v = 32'hEDB88320;  4'h9: v = 32'hF00F9344;
      4'hA: v = 32'hD6D6A3E8;  4'hB: v = 32'hCB61B38C;
      4'hC: v = 32'h9B64C2B0;  4'hD: v = 32'h86D3D2D4;
      4'hE: v = 32'hA00AE278;  default: v = 32'hBDBDF21C;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = crc_nib(c[3:0]) ^ (c >> 4);
    c = crc_nib(c[3:0]) ^ (c >> 4);
    return c;
  endfunction

  // first present optional section at or after 'from'
  function automatic logic [2:0] next_section(input logic [2:0] from,
                                              input logic [4:0] flags);
    logic [2:0] p;
    p = PH_BODY;
    if (from <= PH_XLEN && flags[FL_EXTRA]) p = PH_XLEN;
    else if (from <= PH_NAME && flags[FL_NAME]) p = PH_NAME;
    else if (from <= PH_COMMENT && flags[FL_COMMENT]) p = PH_COMMENT;
    else if (from <= PH_HCRC_LO && flags[FL_HCRC]) p = PH_HCRC_LO;
    return p;
  endfunction

  // little-endian 32-bit value of four bytes, newest byte in [7:0]
  function automatic logic [31:0] le32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gzhc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzhc_if
// Stream channels: member bytes in, one result word per member out.
// ----------------------------------------------------------------------------
interface gzhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       last_byte;

  modport source (output valid, output stream_byte, output last_byte, input ready);
  modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

interface gzhc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] header_length;
  logic [31:0] payload_length;
  logic [31:0] stored_size;
  logic [31:0] stored_crc;

  modport source (output valid, output status, output header_length,
                  output payload_length, output stored_size, output stored_crc,
                  input ready);
  modport sink   (input valid, input status, input header_length,
                  input payload_length, input stored_size, input stored_crc,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/gzhc_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzhc_parse
// Input register plus per-byte header parser, CRC and tail window.
// ----------------------------------------------------------------------------
module gzhc_parse
  import gzhc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  gzhc_in_if.sink   stream,
  input  wire logic slot_free,
  output logic      done,
  output final_t    fin
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        go;

  logic [2:0]  phase,   phase_next;
  logic [31:0] count,   count_next;
  logic [4:0]  flags,   flags_next;
  logic [16:0] extra,   extra_next;
  logic [31:0] crc,     crc_next;
  logic [15:0] hcrc,    hcrc_next;
  logic [2:0]  err,     err_next;
  logic [31:0] pstart,  pstart_next;
  logic [63:0] tail,    tail_next;

  // a last word waits here until the result register can take it
  assign go           = s1_valid && (!s1_last || slot_free);
  assign stream.ready = !s1_valid || go;
  assign done         = go && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.stream_byte;
      s1_last <= stream.last_byte;
    end
  end

  always_comb begin
    phase_next  = phase;
    flags_next  = flags;
    extra_next  = extra;
    crc_next    = crc;
    hcrc_next   = hcrc;
    err_next    = err;
    pstart_next = pstart;
    count_next  = (count == CNT_MAX) ? CNT_MAX : count + 32'd1;
    tail_next   = {tail[55:0], s1_byte};

    case (phase)
      PH_FIXED: begin
        crc_next = crc_byte(crc, s1_byte);
        if (count == 32'd0 && s1_byte != ID1 && err_next == ST_OK) err_next = ST_MAGIC;
        if (count == 32'd1 && s1_byte != ID2 && err_next == ST_OK) err_next = ST_MAGIC;
        if (count == 32'd2 && s1_byte != CM_DEFLATE && err_next == ST_OK)
          err_next = ST_METHOD;
        if (count == 32'd3) begin
          if (s1_byte[7:5] != 3'd0 && err_next == ST_OK) err_next = ST_RSV_FLAGS;
          flags_next = s1_byte[4:0];
        end
        if (count >= 32'd9) phase_next = next_section(PH_XLEN, flags);
      end
      PH_XLEN: begin
        crc_next = crc_byte(crc, s1_byte);
        if (count[0]) begin
          extra_next = {1'b0, s1_byte, tail[7:0]};
          if (extra_next == 17'd0) phase_next = next_section(PH_NAME, flags);
          else phase_next = PH_XDATA;
        end
      end
      PH_XDATA: begin
        crc_next   = crc_byte(crc, s1_byte);
        extra_next = extra - 17'd1;
        if (extra_next == 17'd0) phase_next = next_section(PH_NAME, flags);
      end
      PH_NAME: begin
        crc_next = crc_byte(crc, s1_byte);
        if (s1_byte == 8'd0) phase_next = next_section(PH_COMMENT, flags);
      end
      PH_COMMENT: begin
        crc_next = crc_byte(crc, s1_byte);
        if (s1_byte == 8'd0) phase_next = next_section(PH_HCRC_LO, flags);
      end
      PH_HCRC_LO: begin
        hcrc_next  = {8'd0, s1_byte};
        phase_next = PH_HCRC_HI;
      end
      PH_HCRC_HI: begin
        hcrc_next = {s1_byte, hcrc[7:0]};
        if (~crc[15:0] != hcrc_next && err_next == ST_OK) err_next = ST_HDR_CRC;
        phase_next = PH_BODY;
      end
      default: begin
      end
    endcase

    // payload starts right after the word that closed the header
    if (phase != PH_BODY && phase_next == PH_BODY) pstart_next = count_next;
  end

  assign fin.total  = count_next;
  assign fin.err    = err_next;
  assign fin.body   = (phase_next == PH_BODY);
  assign fin.pstart = pstart_next;
  assign fin.tail   = tail_next;

  always_ff @(posedge clk) begin
    if (rst || done) begin
      phase  <= PH_FIXED;
      count  <= 32'd0;
      flags  <= 5'd0;
      extra  <= 17'd0;
      crc    <= CRC_INIT;
      hcrc   <= 16'd0;
      err    <= ST_OK;
      pstart <= 32'd0;
      tail   <= 64'd0;
    end else if (go) begin
      phase  <= phase_next;
      count  <= count_next;
      flags  <= flags_next;
      extra  <= extra_next;
      crc    <= crc_next;
      hcrc   <= hcrc_next;
      err    <= err_next;
      pstart <= pstart_next;
      tail   <= tail_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gzhc_result.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzhc_result
// Status decision and output register for the end-of-member result.
// ----------------------------------------------------------------------------
module gzhc_result
  import gzhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        done,
  input  wire final_t      fin,
  input  wire logic [31:0] dest_capacity,
  output logic             slot_free,
  gzhc_out_if.source       result
);

  logic [31:0] size;
  logic [31:0] body_len;
  logic [2:0]  st;
  logic        keep;

  assign size     = le32(fin.tail[31:0]);
  assign body_len = fin.total - fin.pstart;

  always_comb begin
    if (fin.total < MIN_MEMBER) st = ST_SHORT;
    else if (fin.err != ST_OK) st = fin.err;
    else if (!fin.body || body_len < TRAILER) st = ST_TRUNC;
    else if (size > dest_capacity) st = ST_TOO_LARGE;
    else st = ST_OK;
  end

  // lengths and trailer fields only reported for ok / too large
  assign keep      = (st == ST_OK) || (st == ST_TOO_LARGE);
  assign slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (done) begin
      result.status         <= st;
      result.header_length  <= keep ? fin.pstart : 32'd0;
      result.payload_length <= keep ? body_len - TRAILER : 32'd0;
      result.stored_size    <= keep ? size : 32'd0;
      result.stored_crc     <= keep ? le32(fin.tail[63:32]) : 32'd0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gzip_member_header_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzip_member_header_checker_top
// Checks the header of one gzip member and reports its layout and trailer.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one member byte per word, last_byte set on the final byte.
//   result : one word per member, issued for the final byte only: status,
//            header and payload lengths, trailer CRC-32 and ISIZE.
//   cfg    : cfg_write/cfg_data load dest_capacity; write only while idle.
// Timing:
//   One byte per cycle while no final byte is held. A byte goes into an input
//   register, is parsed (CRC nibble lookups, field checks, counters) in the
//   next cycle, and the result lands in the output register once it is free.
// Stalls:
//   Non-final bytes flow while a result waits. A final byte is held in the
//   input register until the output register frees up, and stream.ready
//   drops only behind it.
// Reset:
//   rst (synchronous) clears the parser and empties both registers;
//   dest_capacity returns to all ones. After each result the parser goes
//   back to its start state on its own; dest_capacity is kept.
// ----------------------------------------------------------------------------
module gzip_member_header_checker_top
  import gzhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  gzhc_in_if.sink          stream,
  gzhc_out_if.source       result,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] dest_capacity;
  logic        slot_free;
  logic        done;
  final_t      fin;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_capacity <= CNT_MAX;
    end else if (cfg_write) begin
      dest_capacity <= cfg_data;
    end
  end

  // input register and per-byte parser
  gzhc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .slot_free (slot_free),
    .done      (done),
    .fin       (fin)
  );

  // status decision and result register
  gzhc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .fin           (fin),
    .dest_capacity (dest_capacity),
    .slot_free     (slot_free),
    .result        (result)
  );

endmodule
`default_nettype wire

FILE: bench/tb_gzip_member_header_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gzip_member_header_checker_top
// Drives gzip members byte by byte into the header checker. A scoreboard
// parses each accepted byte alongside the block and checks every result word
// field by field. Members are mostly well formed, with random flags, extra
// fields, names, comments and header CRCs, plus damaged and garbage members.
// Several dest_capacity settings are used, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_gzip_member_header_checker_top;
  import gzhc_pkg::*;

  // cycles the receiver refuses results during the back-pressure test
  localparam int RX_HOLD = 300;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hdr_len;
    logic [31:0] body_len;
    logic [31:0] isize;
    logic [31:0] crc32;
  } member_report_t;

  typedef enum {
    MK_CLEAN, MK_CUT, MK_BAD_ID1, MK_BAD_ID2, MK_BAD_CM, MK_RSV_FLAG,
    MK_BAD_HCRC, MK_NOISE
  } member_kind_t;

  // --------------------------------------------------------------------------
  // Scoreboard: parses the byte stream the way the checker should and keeps
  // one expected report per member end.
  // --------------------------------------------------------------------------
  class header_scoreboard;
    logic [31:0]    capacity;
    logic [2:0]     parse_phase;
    logic [31:0]    byte_offset;
    logic [4:0]     flags;
    logic [16:0]    xlen_left;
    logic [31:0]    hdr_crc;
    logic [15:0]    hcrc_field;
    logic [2:0]     first_err;
    logic [31:0]    body_start;
    logic [63:0]    last_bytes;
    member_report_t expected_reports[$];
    int unsigned    failures;
    int unsigned    results_seen;

    function new();
      capacity     = '1;
      failures     = 0;
      results_seen = 0;
      restart();
    endfunction

    // bitwise reflected CRC-32 step, polynomial 0xEDB88320
    static function logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      return r;
    endfunction

    // newest byte sits in [7:0] and is the most significant of the value
    static function logic [31:0] swap32(logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function void restart();
      parse_phase = PH_FIXED;
      byte_offset = '0;
      flags       = '0;
      xlen_left   = '0;
      hdr_crc     = CRC_INIT;
      hcrc_field  = '0;
      first_err   = ST_OK;
      body_start  = '0;
      last_bytes  = '0;
    endfunction

    function void flag_error(logic [2:0] code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    // jump to the first optional section present at or past 'from'
    function void enter_section(logic [2:0] from, logic [31:0] off);
      logic [32:0] nxt;
      if (from <= PH_XLEN && flags[FL_EXTRA]) parse_phase = PH_XLEN;
      else if (from <= PH_NAME && flags[FL_NAME]) parse_phase = PH_NAME;
      else if (from <= PH_COMMENT && flags[FL_COMMENT]) parse_phase = PH_COMMENT;
      else if (from <= PH_HCRC_LO && flags[FL_HCRC]) parse_phase = PH_HCRC_LO;
      else begin
        parse_phase = PH_BODY;
        nxt = {1'b0, off} + 33'd1;
        body_start = nxt[32] ? CNT_MAX : nxt[31:0];
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [31:0]    off;
      logic [7:0]     prev;
      logic [31:0]    isz;
      logic [31:0]    crc_low;
      member_report_t r;
      off  = byte_offset;
      prev = last_bytes[7:0];
      if (parse_phase != PH_HCRC_LO && parse_phase != PH_HCRC_HI &&
          parse_phase != PH_BODY)
        hdr_crc = crc32_update(hdr_crc, b);
      case (parse_phase)
        PH_FIXED: begin
          if (off == 0 && b != ID1) flag_error(ST_MAGIC);
          if (off == 1 && b != ID2) flag_error(ST_MAGIC);
          if (off == 2 && b != CM_DEFLATE) flag_error(ST_METHOD);
          if (off == 3) begin
            if (b[7:5] != 3'd0) flag_error(ST_RSV_FLAGS);
            flags = b[4:0];
          end
          if (off >= 9) enter_section(PH_XLEN, off);
        end
        PH_XLEN: begin
          // second length byte sits at an odd offset
          if (off[0]) begin
            xlen_left = {1'b0, b, prev};
            if (xlen_left == '0) enter_section(PH_NAME, off);
            else parse_phase = PH_XDATA;
          end
        end
        PH_XDATA: begin
          xlen_left = xlen_left - 17'd1;
          if (xlen_left == '0) enter_section(PH_NAME, off);
        end
        PH_NAME:    if (b == 8'd0) enter_section(PH_COMMENT, off);
        PH_COMMENT: if (b == 8'd0) enter_section(PH_HCRC_LO, off);
        PH_HCRC_LO: begin
          hcrc_field  = {8'd0, b};
          parse_phase = PH_HCRC_HI;
        end
        PH_HCRC_HI: begin
          hcrc_field = {b, hcrc_field[7:0]};
          crc_low    = ~hdr_crc;
          if (crc_low[15:0] != hcrc_field) flag_error(ST_HDR_CRC);
          enter_section(PH_BODY, off);
        end
        default: ;
      endcase
      last_bytes = {last_bytes[55:0], b};
      if (byte_offset != CNT_MAX) byte_offset = byte_offset + 32'd1;
      if (!last) return;

      isz = swap32(last_bytes[31:0]);
      r   = '0;
      if (byte_offset < MIN_MEMBER) r.status = ST_SHORT;
      else if (first_err != ST_OK) r.status = first_err;
      else if (parse_phase != PH_BODY || byte_offset - body_start < TRAILER)
        r.status = ST_TRUNC;
      else if (isz > capacity) r.status = ST_TOO_LARGE;
      else r.status = ST_OK;
      if (r.status == ST_OK || r.status == ST_TOO_LARGE) begin
        r.hdr_len  = body_start;
        r.body_len = byte_offset - body_start - TRAILER;
        r.isize    = isz;
        r.crc32    = swap32(last_bytes[63:32]);
      end
      expected_reports.push_back(r);
      restart();
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] g);
      if (g !== e) begin
        failures++;
        if (failures <= 10)
          $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, g);
      end
    endfunction

    function void check_report(member_report_t got);
      member_report_t e;
      results_seen++;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result word with no member pending, status %0d",
                   $time, got.status);
        return;
      end
      e = expected_reports.pop_front();
      check_field("status", {29'd0, e.status}, {29'd0, got.status});
      check_field("header_length", e.hdr_len, got.hdr_len);
      check_field("payload_length", e.body_len, got.body_len);
      check_field("stored_size", e.isize, got.isize);
      check_field("stored_crc", e.crc32, got.crc32);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;

  gzhc_in_if  stream_ch ();
  gzhc_out_if result_ch ();

  gzip_member_header_checker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  header_scoreboard sb = new();

  logic [7:0]  member_q[$];   // bytes of the member being sent
  int unsigned bytes_sent = 0;
  bit          quiet      = 1'b0;  // no idling on either side when set
  bit          hold_req   = 1'b0;  // asks the receiver for a long hold-off

  // --------------------------------------------------------------------------
  // Monitors: both channels sampled at the rising edge, before any update
  // from that edge lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && stream_ch.valid && stream_ch.ready)
      sb.note_byte(stream_ch.stream_byte, stream_ch.last_byte);
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_report({result_ch.status, result_ch.header_length,
                       result_ch.payload_length, result_ch.stored_size,
                       result_ch.stored_crc});
  end

  // --------------------------------------------------------------------------
  // Receiver: random hold-off bursts, or one long hold on request. Each loop
  // pass drives ready once and then advances at least one edge.
  // --------------------------------------------------------------------------
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when no word moves on either channel for too long.
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // offer one word and return at the edge that takes it; valid stays high so
  // back-to-back words need no extra assignment in the same step
  task automatic push_word(input logic [7:0] b, input logic l);
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    stream_ch.last_byte   <= l;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic stream_gap(input int n);
    stream_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_member();
    foreach (member_q[i]) begin
      if (!quiet && $urandom_range(0, 15) == 0) stream_gap($urandom_range(1, 11));
      push_word(member_q[i], i == member_q.size() - 1);
    end
  endtask

  // stop sending and wait for every pending report, plus margin for the
  // block's input and output registers
  task automatic wait_members_done();
    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while idle
  task automatic write_capacity(input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.capacity = v;
  endtask

  // Build one member into member_q. Noise is pay_len+1 random bytes. Extra
  // data is capped at 40 bytes, so a longer XLEN runs past the end.
  task automatic make_member(input member_kind_t kind, input logic [4:0] flg,
                             input logic [15:0] xlen, input int pay_len,
                             input logic [31:0] isize);
    logic [7:0]  flg_byte;
    logic [31:0] hcrc;
    int          cut;
    member_q.delete();
    if (kind == MK_NOISE) begin
      repeat (pay_len + 1) member_q.push_back(8'($urandom));
      return;
    end
    flg_byte = {3'd0, flg};
    if (kind == MK_BAD_HCRC) flg_byte[FL_HCRC] = 1'b1;
    if (kind == MK_RSV_FLAG) flg_byte[7:5] = 3'($urandom_range(1, 7));
    member_q.push_back(kind == MK_BAD_ID1 ? ID1 ^ 8'($urandom_range(1, 255)) : ID1);
    member_q.push_back(kind == MK_BAD_ID2 ? ID2 ^ 8'($urandom_range(1, 255)) : ID2);
    member_q.push_back(kind == MK_BAD_CM ? CM_DEFLATE ^ 8'($urandom_range(1, 255))
                                         : CM_DEFLATE);
    member_q.push_back(flg_byte);
    repeat (6) member_q.push_back(8'($urandom));   // MTIME, XFL, OS
    if (flg_byte[FL_EXTRA]) begin
      member_q.push_back(xlen[7:0]);
      member_q.push_back(xlen[15:8]);
      repeat (xlen > 40 ? 40 : xlen) member_q.push_back(8'($urandom));
    end
    if (flg_byte[FL_NAME]) begin
      repeat ($urandom_range(0, 5)) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (flg_byte[FL_COMMENT]) begin
      repeat ($urandom_range(0, 5)) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (flg_byte[FL_HCRC]) begin
      hcrc = CRC_INIT;
      foreach (member_q[i]) hcrc = header_scoreboard::crc32_update(hcrc, member_q[i]);
      hcrc = ~hcrc;
      if (kind == MK_BAD_HCRC) hcrc[15:0] = hcrc[15:0] ^ (16'd1 << $urandom_range(0, 15));
      member_q.push_back(hcrc[7:0]);
      member_q.push_back(hcrc[15:8]);
    end
    repeat (pay_len) member_q.push_back(8'($urandom));
    repeat (4) member_q.push_back(8'($urandom));     // trailer CRC-32
    for (int i = 0; i < 4; i++) member_q.push_back(isize[8*i +: 8]);
    if (kind == MK_CUT) begin
      cut = $urandom_range(1, member_q.size() - 1);
      while (member_q.size() > cut) void'(member_q.pop_back());
    end
  endtask

  // trailer sizes around the current capacity and at the extremes
  function automatic logic [31:0] pick_isize();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return CNT_MAX;
      2:       return sb.capacity;
      3:       return sb.capacity + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_members(input int unsigned byte_goal,
                                input int unsigned result_goal);
    int unsigned  b0;
    int unsigned  r0;
    int           pick;
    member_kind_t k;
    b0 = bytes_sent;
    r0 = sb.results_seen;
    while (bytes_sent - b0 < byte_goal || sb.results_seen - r0 < result_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 66)      k = MK_CLEAN;
      else if (pick < 74) k = MK_CUT;
      else if (pick < 77) k = MK_BAD_ID1;
      else if (pick < 80) k = MK_BAD_ID2;
      else if (pick < 84) k = MK_BAD_CM;
      else if (pick < 88) k = MK_RSV_FLAG;
      else if (pick < 94) k = MK_BAD_HCRC;
      else                k = MK_NOISE;
      make_member(k, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 6)),
                  $urandom_range(0, 12), pick_isize());
      send_member();
      if (!quiet && $urandom_range(0, 7) == 0) stream_gap($urandom_range(1, 11));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] caps[4];
    stream_ch.valid       <= 1'b0;
    stream_ch.stream_byte <= 8'd0;
    stream_ch.last_byte   <= 1'b0;
    cfg_write             <= 1'b0;
    cfg_data              <= 32'd0;
    rst                   <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: capacity still at its reset value (all ones)
    make_member(MK_CLEAN, 5'h00, 16'd0, 0, 32'd0);        // minimal 18-byte member
    send_member();
    make_member(MK_CLEAN, 5'h1F, 16'd3, 5, CNT_MAX);     // every flag, good HCRC
    send_member();
    make_member(MK_CLEAN, 5'h04, 16'd0, 2, 32'd7);       // empty extra field
    send_member();
    make_member(MK_BAD_ID1, 5'h00, 16'd0, 3, 32'd1);
    send_member();
    make_member(MK_BAD_ID2, 5'h08, 16'd0, 3, 32'd1);
    send_member();
    make_member(MK_BAD_CM, 5'h10, 16'd0, 3, 32'd1);
    send_member();
    make_member(MK_RSV_FLAG, 5'h00, 16'd0, 3, 32'd1);
    send_member();
    make_member(MK_BAD_HCRC, 5'h1E, 16'd2, 3, 32'd1);
    send_member();
    make_member(MK_CLEAN, 5'h04, 16'hFFFF, 4, 32'd1);    // extra runs past end
    send_member();
    make_member(MK_NOISE, 5'h00, 16'd0, 0, 32'd0);       // one-byte member
    send_member();
    make_member(MK_NOISE, 5'h00, 16'd0, 16, 32'd0);      // 17 bytes, one short
    send_member();
    make_member(MK_NOISE, 5'h00, 16'd0, 23, 32'd0);
    foreach (member_q[i]) member_q[i] = 8'hFF;
    send_member();
    make_member(MK_NOISE, 5'h00, 16'd0, 23, 32'd0);
    foreach (member_q[i]) member_q[i] = 8'h00;
    send_member();
    // header complete but fewer than eight bytes after it
    make_member(MK_CLEAN, 5'h1C, 16'd4, 0, 32'd5);
    repeat (3) void'(member_q.pop_back());
    send_member();
    make_member(MK_CUT, 5'h1E, 16'd2, 4, 32'd9);
    send_member();
    wait_members_done();

    // trailer size right at and just past the capacity
    write_capacity(32'd1000);
    make_member(MK_CLEAN, 5'h02, 16'd0, 1, 32'd1000);
    send_member();
    make_member(MK_CLEAN, 5'h02, 16'd0, 1, 32'd1001);
    send_member();
    wait_members_done();

    // back-pressure: results held off while short members keep coming, so
    // the output register fills and a final byte stalls the input
    hold_req = 1'b1;
    repeat (6) begin
      make_member(MK_NOISE, 5'h00, 16'd0, $urandom_range(0, 3), 32'd0);
      send_member();
    end
    make_member(MK_CLEAN, 5'($urandom_range(0, 31)), 16'd1, 2, pick_isize());
    send_member();
    wait_members_done();

    // random phases over several capacities, extremes included; the last
    // phase runs with no idling on either side
    caps[0] = 32'd0;
    caps[1] = $urandom;
    caps[2] = 32'($urandom_range(0, 255));
    caps[3] = CNT_MAX;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      if (p == 3) quiet = 1'b1;
      random_members(20, 0);
      wait_members_done();
    end

    if (sb.failures == 0 && sb.expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
